[hw/rtl/bth_pkg.sv]
// ----------------------------------------------------------------------------
// bth_pkg
// Shared types and constants of the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package bth_pkg;

  localparam int HEAP_BYTES_DEF = 4096;
  localparam int OVERHEAD_DEF   = 8;

  localparam int CFG_W     = 13;
  localparam int REQ_W     = 13;
  localparam int UADDR_W   = 12;
  localparam int FREED_W   = 13;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_W-1:0] HEAP_SIZE_RST = 13'd4096;
  localparam logic [CFG_W-1:0] MIN_SIZE_RST  = 13'd16;

  // register index, taken from paddr[2]
  localparam logic REG_HEAP_SIZE = 1'b0;
  localparam logic REG_MIN_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  // per-field write enables of the tag memory
  typedef struct packed {
    logic size;
    logic alloc;
    logic end_tag;
    logic nxt;
    logic prv;
  } mem_we_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_INI_SET,
    S_INI_PUSH,
    S_ALC_RD,
    S_ALC_CHK,
    S_ALC_SPLIT,
    S_ALC_PUSH,
    S_ALC_OWN,
    S_FRE_RD_S,
    S_FRE_CHK_S,
    S_FRE_RD_N,
    S_FRE_CHK_N,
    S_FRE_ZN,
    S_FRE_PRE,
    S_FRE_CHK_E,
    S_FRE_CHK_P,
    S_FRE_ZS,
    S_FRE_FIN,
    S_FRE_PUSH,
    S_UNL_NX,
    S_UNL_PV,
    S_PUSH_N,
    S_PUSH_H,
    S_SB_TAG,
    S_SB_END,
    S_DONE
  } state_t;

endpackage

[hw/rtl/bth_mem.sv]
// ----------------------------------------------------------------------------
// bth_mem
// Tag memory: one word per heap byte holding size, allocated flag, end
// size copy and free-list links. Per-field writes, registered read.
// ----------------------------------------------------------------------------
module bth_mem #(
  parameter int AW = 12,
  parameter int PW = 13
) (
  input  logic                 clk,
  input  logic                 re,
  input  logic [AW-1:0]        ra,
  output logic [4*PW:0]        rdata,
  input  bth_pkg::mem_we_t     we,
  input  logic [AW-1:0]        wa,
  input  logic [4*PW:0]        wdata
);
  import bth_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [4*PW:0] mem_r [DEPTH];
  logic [4*PW:0] rdata_r;

  // layout: {size, alloc, end, next, prev}
  always_ff @(posedge clk) begin
    if (we.prv)     mem_r[wa][PW-1:0]       <= wdata[PW-1:0];
    if (we.nxt)     mem_r[wa][2*PW-1:PW]    <= wdata[2*PW-1:PW];
    if (we.end_tag) mem_r[wa][3*PW-1:2*PW]  <= wdata[3*PW-1:2*PW];
    if (we.alloc)   mem_r[wa][3*PW]         <= wdata[3*PW];
    if (we.size)    mem_r[wa][4*PW:3*PW+1]  <= wdata[4*PW:3*PW+1];
    if (re)         rdata_r <= mem_r[ra];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/bth_cfg.sv]
// ----------------------------------------------------------------------------
// bth_cfg
// APB register file: heap size and minimum block size.
// ----------------------------------------------------------------------------
module bth_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bth_pkg::CFG_AW-1:0]    paddr,
  input  logic [bth_pkg::CFG_DW-1:0]    pwdata,
  output logic [bth_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output logic [bth_pkg::CFG_W-1:0]     heap_size,
  output logic [bth_pkg::CFG_W-1:0]     min_size
);
  import bth_pkg::*;

  logic [CFG_W-1:0] heap_size_r, heap_size_nxt;
  logic [CFG_W-1:0] min_size_r, min_size_nxt;
  logic             wr;

  assign wr = psel & penable & pwrite;

  always_comb begin
    heap_size_nxt = heap_size_r;
    min_size_nxt  = min_size_r;
    if (wr) begin
      unique case (paddr[2])
        REG_HEAP_SIZE: heap_size_nxt = pwdata[CFG_W-1:0];
        REG_MIN_SIZE:  min_size_nxt  = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= HEAP_SIZE_RST;
      min_size_r  <= MIN_SIZE_RST;
    end else begin
      heap_size_r <= heap_size_nxt;
      min_size_r  <= min_size_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HEAP_SIZE: prdata = CFG_DW'(heap_size_r);
      REG_MIN_SIZE:  prdata = CFG_DW'(min_size_r);
      default:       prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign heap_size = heap_size_r;
  assign min_size  = min_size_r;

endmodule

[hw/rtl/bth_ctrl.sv]
// ----------------------------------------------------------------------------
// bth_ctrl
// Sequencer: walks the free list, splits, merges and relinks blocks by
// read-modify-write of the tag memory, one access per cycle.
// ----------------------------------------------------------------------------
module bth_ctrl #(
  parameter int HEAP_BYTES     = 4096,
  parameter int OVERHEAD_BYTES = 8,
  parameter int AW             = 12,
  parameter int PW             = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bth_pkg::op_t                  op,
  input  logic [bth_pkg::REQ_W-1:0]     request_size,
  input  logic [bth_pkg::UADDR_W-1:0]   user_address,
  input  logic [bth_pkg::CFG_W-1:0]     heap_size,
  input  logic [bth_pkg::CFG_W-1:0]     min_size,
  output logic                          out_valid,
  output bth_pkg::status_t              status,
  output logic [bth_pkg::UADDR_W-1:0]   address,
  output logic [bth_pkg::FREED_W-1:0]   freed_size,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_ra,
  input  logic [4*PW:0]                 mem_rdata,
  output bth_pkg::mem_we_t              mem_we,
  output logic [AW-1:0]                 mem_wa,
  output logic [4*PW:0]                 mem_wdata
);
  import bth_pkg::*;

  // wide enough for any sum of address, size and request
  localparam int XW = (PW + 7 > 14) ? PW + 7 : 14;
  localparam logic [XW-1:0] NIL_X = XW'(HEAP_BYTES);
  localparam logic [XW-1:0] OH_X  = XW'(OVERHEAD_BYTES);
  localparam logic [PW-1:0] NIL_P = PW'(HEAP_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_BYTES - 1);

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  logic [PW-1:0]      head_r, head_nxt;
  logic [PW-1:0]      heap_end_r, heap_end_nxt;
  logic [PW-1:0]      n_r, n_nxt;
  logic [PW-1:0]      steps_r, steps_nxt;
  logic [XW-1:0]      need_r, need_nxt;
  logic [PW-1:0]      size_r, size_nxt;
  logic [PW-1:0]      nsz_r, nsz_nxt;
  logic [AW-1:0]      s_r, s_nxt;
  logic [PW-1:0]      nx_r, nx_nxt;
  logic [PW-1:0]      ps_r, ps_nxt;
  logic [UADDR_W-1:0] ua_r, ua_nxt;
  logic [PW-1:0]      u_n_r, u_n_nxt;
  logic [PW-1:0]      u_nx_r, u_nx_nxt;
  logic [PW-1:0]      u_pv_r, u_pv_nxt;
  logic [AW-1:0]      pn_r, pn_nxt;
  logic [AW-1:0]      sb_s_r, sb_s_nxt;
  logic [PW-1:0]      sb_size_r, sb_size_nxt;
  logic               sb_alloc_r, sb_alloc_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  status_t            status_r, status_nxt;
  logic [UADDR_W-1:0] addr_r, addr_nxt;
  logic [FREED_W-1:0] freed_r, freed_nxt;

  logic [PW-1:0] rd_size, rd_end, rd_next, rd_prev;
  logic          rd_alloc;

  assign rd_prev  = mem_rdata[PW-1:0];
  assign rd_next  = mem_rdata[2*PW-1:PW];
  assign rd_end   = mem_rdata[3*PW-1:2*PW];
  assign rd_alloc = mem_rdata[3*PW];
  assign rd_size  = mem_rdata[4*PW:3*PW+1];

  logic [XW-1:0] he_x, need_a, need_sel, hs_x, rem_x, s_full, nx_x, sum_x;
  logic          accept, walk_go, alc_fit, alc_split;
  logic          fre_s_ok, fre_s_hit, fre_n_merge, fre_e_ok;

  assign accept   = start && (state_r == S_IDLE);
  assign he_x     = XW'(heap_end_r);
  assign need_a   = XW'(request_size) + OH_X;
  assign need_sel = (need_a < XW'(min_size)) ? XW'(min_size) : need_a;
  assign hs_x     = (XW'(heap_size) > NIL_X) ? NIL_X : XW'(heap_size);

  assign walk_go  = (XW'(n_r) < NIL_X) && (XW'(steps_r) < NIL_X);
  assign alc_fit  = (XW'(rd_size) >= need_r) && (rd_size != '0)
                    && (XW'(n_r) + XW'(rd_size) <= he_x);
  assign rem_x    = XW'(rd_size) - need_r;
  assign alc_split = (rem_x >= XW'(min_size)) && (rem_x != '0);

  assign s_full   = XW'(ua_r) - OH_X;
  assign fre_s_ok = (XW'(ua_r) >= OH_X) && (s_full < he_x) && (s_full < NIL_X);
  assign nx_x     = XW'(s_r) + XW'(rd_size);
  assign fre_s_hit = rd_alloc && (rd_size != '0) && (nx_x <= he_x);
  assign fre_n_merge = !rd_alloc && (rd_size != '0)
                       && (XW'(nx_r) + XW'(rd_size) <= he_x);
  assign fre_e_ok = (rd_end != '0) && (XW'(rd_end) <= XW'(s_r));
  assign sum_x    = XW'(sb_s_r) + XW'(sb_size_r) - XW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_INIT:  state_nxt = S_CLR;
            OP_ALLOC: state_nxt = S_ALC_RD;
            OP_FREE:  state_nxt = S_FRE_RD_S;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR:       if (clr_r == CLR_LAST) state_nxt = S_INI_SET;
      S_INI_SET:   state_nxt = (heap_end_r != '0) ? S_SB_TAG : S_DONE;
      S_INI_PUSH:  state_nxt = S_PUSH_N;
      S_ALC_RD:    state_nxt = walk_go ? S_ALC_CHK : S_DONE;
      S_ALC_CHK:   state_nxt = alc_fit ? S_UNL_NX : S_ALC_RD;
      S_ALC_SPLIT: state_nxt = S_SB_TAG;
      S_ALC_PUSH:  state_nxt = S_PUSH_N;
      S_ALC_OWN:   state_nxt = S_SB_TAG;
      S_FRE_RD_S:  state_nxt = fre_s_ok ? S_FRE_CHK_S : S_DONE;
      S_FRE_CHK_S: begin
        if (!fre_s_hit) state_nxt = S_DONE;
        else if (nx_x < he_x) state_nxt = S_FRE_RD_N;
        else state_nxt = S_FRE_PRE;
      end
      S_FRE_RD_N:  state_nxt = S_FRE_CHK_N;
      S_FRE_CHK_N: state_nxt = fre_n_merge ? S_UNL_NX : S_FRE_PRE;
      S_FRE_ZN:    state_nxt = S_FRE_PRE;
      S_FRE_PRE:   state_nxt = (s_r != '0) ? S_FRE_CHK_E : S_FRE_FIN;
      S_FRE_CHK_E: state_nxt = fre_e_ok ? S_FRE_CHK_P : S_FRE_FIN;
      S_FRE_CHK_P: state_nxt = !rd_alloc ? S_UNL_NX : S_FRE_FIN;
      S_FRE_ZS:    state_nxt = S_FRE_FIN;
      S_FRE_FIN:   state_nxt = S_SB_TAG;
      S_FRE_PUSH:  state_nxt = S_PUSH_N;
      S_UNL_NX:    state_nxt = S_UNL_PV;
      S_UNL_PV:    state_nxt = ret_r;
      S_PUSH_N:    state_nxt = S_PUSH_H;
      S_PUSH_H:    state_nxt = ret_r;
      S_SB_TAG:    state_nxt = S_SB_END;
      S_SB_END:    state_nxt = ret_r;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory accesses
  always_comb begin
    ret_nxt      = ret_r;
    head_nxt     = head_r;
    heap_end_nxt = heap_end_r;
    n_nxt        = n_r;
    steps_nxt    = steps_r;
    need_nxt     = need_r;
    size_nxt     = size_r;
    nsz_nxt      = nsz_r;
    s_nxt        = s_r;
    nx_nxt       = nx_r;
    ps_nxt       = ps_r;
    ua_nxt       = ua_r;
    u_n_nxt      = u_n_r;
    u_nx_nxt     = u_nx_r;
    u_pv_nxt     = u_pv_r;
    pn_nxt       = pn_r;
    sb_s_nxt     = sb_s_r;
    sb_size_nxt  = sb_size_r;
    sb_alloc_nxt = sb_alloc_r;
    clr_nxt      = clr_r;
    status_nxt   = status_r;
    addr_nxt     = addr_r;
    freed_nxt    = freed_r;
    mem_re       = 1'b0;
    mem_ra       = '0;
    mem_we       = '0;
    mem_wa       = '0;
    mem_wdata    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          addr_nxt   = '0;
          freed_nxt  = '0;
          ua_nxt     = user_address;
          need_nxt   = need_sel;
          n_nxt      = head_r;
          steps_nxt  = '0;
          clr_nxt    = '0;
          if (op == OP_INIT) begin
            heap_end_nxt = hs_x[PW-1:0];
            head_nxt     = NIL_P;
          end
        end
      end
      S_CLR: begin
        mem_we  = '{size: 1'b1, alloc: 1'b1, end_tag: 1'b1, nxt: 1'b1, prv: 1'b1};
        mem_wa  = clr_r;
        clr_nxt = clr_r + AW'(1);
      end
      S_INI_SET: begin
        sb_s_nxt     = '0;
        sb_size_nxt  = heap_end_r;
        sb_alloc_nxt = 1'b0;
        ret_nxt      = S_INI_PUSH;
      end
      S_INI_PUSH: begin
        pn_nxt  = '0;
        ret_nxt = S_DONE;
      end
      S_ALC_RD: begin
        if (walk_go) begin
          mem_re = 1'b1;
          mem_ra = n_r[AW-1:0];
        end else begin
          status_nxt = ST_NOFIT;
        end
      end
      S_ALC_CHK: begin
        if (alc_fit) begin
          u_n_nxt  = n_r;
          u_nx_nxt = rd_next;
          u_pv_nxt = rd_prev;
          addr_nxt = UADDR_W'(XW'(n_r) + OH_X);
          if (alc_split) begin
            size_nxt = rem_x[PW-1:0];
            ret_nxt  = S_ALC_SPLIT;
          end else begin
            need_nxt = XW'(rd_size);
            ret_nxt  = S_ALC_OWN;
          end
        end else begin
          n_nxt     = rd_next;
          steps_nxt = steps_r + PW'(1);
        end
      end
      S_ALC_SPLIT: begin
        sb_s_nxt     = AW'(XW'(n_r) + need_r);
        sb_size_nxt  = size_r;
        sb_alloc_nxt = 1'b0;
        ret_nxt      = S_ALC_PUSH;
      end
      S_ALC_PUSH: begin
        pn_nxt  = AW'(XW'(n_r) + need_r);
        ret_nxt = S_ALC_OWN;
      end
      S_ALC_OWN: begin
        sb_s_nxt     = n_r[AW-1:0];
        sb_size_nxt  = need_r[PW-1:0];
        sb_alloc_nxt = 1'b1;
        ret_nxt      = S_DONE;
      end
      S_FRE_RD_S: begin
        s_nxt = s_full[AW-1:0];
        if (fre_s_ok) begin
          mem_re = 1'b1;
          mem_ra = s_full[AW-1:0];
        end else begin
          status_nxt = ST_BADFREE;
        end
      end
      S_FRE_CHK_S: begin
        if (fre_s_hit) begin
          mem_we.alloc = 1'b1;
          mem_wa       = s_r;
          size_nxt     = rd_size;
          nx_nxt       = nx_x[PW-1:0];
        end else begin
          status_nxt = ST_BADFREE;
        end
      end
      S_FRE_RD_N: begin
        mem_re = 1'b1;
        mem_ra = nx_r[AW-1:0];
      end
      S_FRE_CHK_N: begin
        if (fre_n_merge) begin
          u_n_nxt  = nx_r;
          u_nx_nxt = rd_next;
          u_pv_nxt = rd_prev;
          nsz_nxt  = rd_size;
          ret_nxt  = S_FRE_ZN;
        end
      end
      S_FRE_ZN: begin
        mem_we.size = 1'b1;
        mem_wa      = nx_r[AW-1:0];
        size_nxt    = PW'(XW'(size_r) + XW'(nsz_r));
      end
      S_FRE_PRE: begin
        if (s_r != '0) begin
          mem_re = 1'b1;
          mem_ra = s_r - AW'(1);
        end
      end
      S_FRE_CHK_E: begin
        if (fre_e_ok) begin
          ps_nxt = rd_end;
          mem_re = 1'b1;
          mem_ra = AW'(XW'(s_r) - XW'(rd_end));
        end
      end
      S_FRE_CHK_P: begin
        if (!rd_alloc) begin
          u_n_nxt  = PW'(XW'(s_r) - XW'(ps_r));
          u_nx_nxt = rd_next;
          u_pv_nxt = rd_prev;
          ret_nxt  = S_FRE_ZS;
        end
      end
      S_FRE_ZS: begin
        mem_we.size = 1'b1;
        mem_wa      = s_r;
        size_nxt    = PW'(XW'(size_r) + XW'(ps_r));
        s_nxt       = AW'(XW'(s_r) - XW'(ps_r));
      end
      S_FRE_FIN: begin
        sb_s_nxt     = s_r;
        sb_size_nxt  = size_r;
        sb_alloc_nxt = 1'b0;
        ret_nxt      = S_FRE_PUSH;
      end
      S_FRE_PUSH: begin
        pn_nxt    = s_r;
        freed_nxt = FREED_W'(XW'(size_r));
        ret_nxt   = S_DONE;
      end
      S_UNL_NX: begin
        if (head_r == u_n_r) head_nxt = u_nx_r;
        if (XW'(u_nx_r) < NIL_X) begin
          mem_we.prv = 1'b1;
          mem_wa     = u_nx_r[AW-1:0];
          mem_wdata[PW-1:0] = u_pv_r;
        end
      end
      S_UNL_PV: begin
        if (XW'(u_pv_r) < NIL_X) begin
          mem_we.nxt = 1'b1;
          mem_wa     = u_pv_r[AW-1:0];
          mem_wdata[2*PW-1:PW] = u_nx_r;
        end
      end
      S_PUSH_N: begin
        mem_we.nxt = 1'b1;
        mem_we.prv = 1'b1;
        mem_wa     = pn_r;
        mem_wdata[2*PW-1:PW] = head_r;
        mem_wdata[PW-1:0]    = NIL_P;
      end
      S_PUSH_H: begin
        if (XW'(head_r) < NIL_X) begin
          mem_we.prv = 1'b1;
          mem_wa     = head_r[AW-1:0];
          mem_wdata[PW-1:0] = PW'(pn_r);
        end
        head_nxt = PW'(pn_r);
      end
      S_SB_TAG: begin
        mem_we.size  = 1'b1;
        mem_we.alloc = 1'b1;
        mem_wa       = sb_s_r;
        mem_wdata[4*PW:3*PW+1] = sb_size_r;
        mem_wdata[3*PW]        = sb_alloc_r;
      end
      S_SB_END: begin
        mem_we.end_tag = 1'b1;
        mem_wa         = sum_x[AW-1:0];
        mem_wdata[3*PW-1:2*PW] = sb_size_r;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_DONE;
      head_r     <= NIL_P;
      heap_end_r <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      head_r     <= head_nxt;
      heap_end_r <= heap_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    steps_r    <= steps_nxt;
    need_r     <= need_nxt;
    size_r     <= size_nxt;
    nsz_r      <= nsz_nxt;
    s_r        <= s_nxt;
    nx_r       <= nx_nxt;
    ps_r       <= ps_nxt;
    ua_r       <= ua_nxt;
    u_n_r      <= u_n_nxt;
    u_nx_r     <= u_nx_nxt;
    u_pv_r     <= u_pv_nxt;
    pn_r       <= pn_nxt;
    sb_s_r     <= sb_s_nxt;
    sb_size_r  <= sb_size_nxt;
    sb_alloc_r <= sb_alloc_nxt;
    clr_r      <= clr_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    freed_r    <= freed_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign status     = status_r;
  assign address    = addr_r;
  assign freed_size = freed_r;

endmodule

[hw/rtl/boundary_tag_heap_allocator.sv]
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// First-fit boundary-tag heap manager with a doubly linked free list.
// ----------------------------------------------------------------------------
// An op is taken when start is high and busy is low; busy stays high through
// the result beat, which is shown for one cycle on out_valid and cannot be
// held off. All block tags and list links live in one single-port-style tag
// memory (one access per cycle, read data registered), so the time per op
// is set by how many tag accesses it needs: allocate reads each free-list
// entry it visits, then unlinks and retags a whole block, or also pushes
// and tags a remainder when one is split off (it ends at once when the walk
// finds nothing); free needs more accesses the more neighbors merge (and
// ends early when the address is rejected); init sweeps the whole tag memory
// to zero, then tags a nonzero heap as one free block. Every op then ends
// with its one-cycle result beat. No op is accepted while an earlier op is still running.
module boundary_tag_heap_allocator #(
  parameter int HEAP_BYTES     = bth_pkg::HEAP_BYTES_DEF,
  parameter int OVERHEAD_BYTES = bth_pkg::OVERHEAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic [bth_pkg::REQ_W-1:0]     in_request_size,
  input  logic [bth_pkg::UADDR_W-1:0]   in_user_address,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [bth_pkg::UADDR_W-1:0]   out_address,
  output logic [bth_pkg::FREED_W-1:0]   out_freed_size,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bth_pkg::CFG_AW-1:0]    paddr,
  input  logic [bth_pkg::CFG_DW-1:0]    pwdata,
  output logic [bth_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import bth_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int PW = $clog2(HEAP_BYTES + 1);

  logic [CFG_W-1:0] heap_size, min_size;
  logic             mem_re;
  logic [AW-1:0]    mem_ra, mem_wa;
  logic [4*PW:0]    mem_rdata, mem_wdata;
  mem_we_t          mem_we;
  status_t          status;

  bth_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .heap_size (heap_size),
    .min_size  (min_size)
  );

  bth_mem #(.AW(AW), .PW(PW)) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .ra    (mem_ra),
    .rdata (mem_rdata),
    .we    (mem_we),
    .wa    (mem_wa),
    .wdata (mem_wdata)
  );

  bth_ctrl #(
    .HEAP_BYTES     (HEAP_BYTES),
    .OVERHEAD_BYTES (OVERHEAD_BYTES),
    .AW             (AW),
    .PW             (PW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .op           (op_t'(in_op)),
    .request_size (in_request_size),
    .user_address (in_user_address),
    .heap_size    (heap_size),
    .min_size     (min_size),
    .out_valid    (out_valid),
    .status       (status),
    .address      (out_address),
    .freed_size   (out_freed_size),
    .mem_re       (mem_re),
    .mem_ra       (mem_ra),
    .mem_rdata    (mem_rdata),
    .mem_we       (mem_we),
    .mem_wa       (mem_wa),
    .mem_wdata    (mem_wdata)
  );

  assign out_status = status;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted op did not raise busy");

  a_result_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("result beat did not end the op");

  a_result_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat outside an op");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_address == '0) && (out_freed_size == '0))
    else $error("error result carries nonzero fields");
`endif

endmodule
